FILE: rtl/abkf_pkg.sv
`default_nettype none

package abkf_pkg;

  // Field and register widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 31;
  localparam int unsigned DT_W   = 24;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned FRAC_W = 24;

  // Shared multiplier: operand A covers the 35-bit covariance term,
  // operand B a signed 32-bit value or a zero-extended register
  localparam int unsigned MA_W   = 35;
  localparam int unsigned MB_W   = 33;
  localparam int unsigned PROD_W = MA_W + MB_W;
  localparam int unsigned RND_W  = PROD_W - FRAC_W;
  localparam int unsigned ACC_W  = RND_W + 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;
  localparam logic [IDX_W-1:0] CFG_TIME_STEP   = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 31'd16777;
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 31'd50332;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 31'd503316;
  localparam logic [DT_W-1:0]  TIME_STEP_RST   = 24'd167772;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef logic signed [DATA_W-1:0] s32_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Clamp a wide signed sum to signed 32 bits
  function automatic s32_t sat32(input acc_t v);
    logic [ACC_W-DATA_W:0] hi;
    hi = v[ACC_W-1:DATA_W-1];
    if ((&hi) || (~|hi)) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return S32_MIN;
    end else begin
      return S32_MAX;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/abkf_mul.sv
`default_nettype none

module abkf_mul import abkf_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic signed [MA_W-1:0] a_i,
  input  wire logic signed [MB_W-1:0] b_i,
  output rnd_t                        rnd_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] biased;

  // Register the exact product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  // Scale down by the fraction width, nearest with ties toward plus infinity
  assign biased = prod_q + (PROD_W'(1) <<< (FRAC_W - 1));
  assign rnd_o  = biased[PROD_W-1:FRAC_W];

endmodule

`default_nettype wire

FILE: rtl/abkf_div.sv
`default_nettype none

module abkf_div import abkf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire s32_t              num_i,
  input  wire logic [DATA_W-1:0] den_i,
  output logic                   done_o,
  output s32_t                   quo_o
);

  // Quotient bits left once the top of the shifted dividend is below den
  localparam int unsigned QB_W  = DATA_W - 1;
  localparam int unsigned HI_W  = DATA_W + FRAC_W - QB_W;
  localparam int unsigned CNT_W = $clog2(QB_W + 1);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic              sat_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q;
  logic [QB_W-1:0]   sh_q;
  logic [DATA_W-1:0] den_q;

  logic [DATA_W-1:0] mag;
  logic [HI_W-1:0]   hi;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   shifted;
  logic              ge;
  logic [DATA_W-1:0] q_ext;

  assign mag     = num_i[DATA_W-1] ? (~num_i + 1'b1) : num_i;
  assign hi      = mag[DATA_W-1:DATA_W-HI_W];
  assign shifted = {rem_q, sh_q[QB_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign trial   = shifted - {1'b0, den_q};

  // Control: start, iterate one quotient bit a cycle, flag completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (DATA_W'(hi) >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(QB_W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring division on the magnitude
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DATA_W-1];
      sat_q <= DATA_W'(hi) >= den_i;
      den_q <= den_i;
      rem_q <= DATA_W'(hi);
      sh_q  <= {mag[DATA_W-HI_W-1:0], {FRAC_W{1'b0}}};
    end else if (busy_q) begin
      rem_q <= ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      sh_q  <= {sh_q[QB_W-2:0], ge};
    end
  end

  // Apply sign, clamp when the quotient overflows 32 bits
  assign q_ext  = {1'b0, sh_q};
  assign done_o = done_q;
  always_comb begin
    if (sat_q) begin
      quo_o = neg_q ? S32_MIN : S32_MAX;
    end else begin
      quo_o = neg_q ? s32_t'(~q_ext + 1'b1) : s32_t'(q_ext);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/angle_bias_kalman_filter_top.sv
// Channel   Direction  Payload                                   Handshake
// s_axis    in         tdata[31:0] measured_angle, [63:32] gyro  tvalid/tready
// m_axis    out        tdata[31:0] filtered_angle, [63:32] bias  tvalid/tready
// cfg       in         cfg_idx_i selects register, cfg_data_i    cfg_we_i
//
// Each sample takes ten products on one shared 35x33 multiplier, each in a multiply
// state and a write-back state, and two gains on one restoring divider (start, 31
// quotient bits, completion), and ends with the output load. A saturating gain
// flags completion at start without iterating; a non-positive innovation variance
// skips both divisions.
// s_axis_tready is high only in idle; a held result stalls the next output load.
`default_nettype none

module angle_bias_kalman_filter_top import abkf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [63:0]       s_axis_tdata,   // measured_angle, gyro_rate
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [63:0]            m_axis_tdata,   // filtered_angle, bias_estimate
  input  wire logic              cfg_we_i,
  input  wire logic [IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_WB   = 3'd2;
  localparam logic [2:0] ST_DIV0 = 3'd3;
  localparam logic [2:0] ST_DW0  = 3'd4;
  localparam logic [2:0] ST_DIV1 = 3'd5;
  localparam logic [2:0] ST_DW1  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  // Product steps
  localparam logic [3:0] SP_APRED = 4'd0;
  localparam logic [3:0] SP_D     = 4'd1;
  localparam logic [3:0] SP_P0X   = 4'd2;
  localparam logic [3:0] SP_P11   = 4'd3;
  localparam logic [3:0] SP_ANG   = 4'd4;
  localparam logic [3:0] SP_BIAS  = 4'd5;
  localparam logic [3:0] SP_U00   = 4'd6;
  localparam logic [3:0] SP_U01   = 4'd7;
  localparam logic [3:0] SP_U10   = 4'd8;
  localparam logic [3:0] SP_U11   = 4'd9;

  logic [2:0] state_q, state_d;
  logic [3:0] step_q, step_d;

  logic [CFG_W-1:0] apn_q, bpn_q, rn_q;
  logic [DT_W-1:0]  dt_q;

  s32_t meas_q, gyro_q;
  s32_t ae_q, bias_q, c00_q, c01_q, c10_q, c11_q;
  s32_t apred_q, y_q, pp00_q, pp01_q, pp10_q, pp11_q, k0_q, k1_q;
  logic signed [DATA_W:0]   d_q;
  logic signed [MA_W-1:0]   t_q;
  s32_t ang_out_q, bias_out_q;
  logic out_valid_q;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MB_W-1:0] dt_op;
  rnd_t m_rnd;
  logic mul_en;

  logic signed [DATA_W+1:0] s_sum;
  logic s_pos;
  logic div_start, div_done;
  s32_t div_num, div_quo;
  logic in_hs, out_load;

  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  assign mul_en        = (state_q == ST_MUL);

  // Innovation variance from the predicted angle variance
  assign s_sum = (DATA_W+2)'(pp00_q) + (DATA_W+2)'(rn_q);
  assign s_pos = !s_sum[DATA_W+1] && (s_sum != '0);

  assign div_start = (state_q == ST_DIV0 && s_pos) || (state_q == ST_DIV1);
  assign div_num   = (state_q == ST_DIV0) ? pp00_q : pp10_q;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apn_q <= ANGLE_NOISE_RST;
      bpn_q <= BIAS_NOISE_RST;
      rn_q  <= MEAS_NOISE_RST;
      dt_q  <= TIME_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANGLE_NOISE: apn_q <= cfg_data_i;
        CFG_BIAS_NOISE:  bpn_q <= cfg_data_i;
        CFG_MEAS_NOISE:  rn_q  <= cfg_data_i;
        CFG_TIME_STEP:   dt_q  <= cfg_data_i[DT_W-1:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands for the current step
  assign dt_op = $signed({{(MB_W-DT_W){1'b0}}, dt_q});
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      SP_APRED: begin
        mul_a = MA_W'(gyro_q) - MA_W'(bias_q);
        mul_b = dt_op;
      end
      SP_D: begin
        mul_a = MA_W'(c11_q);
        mul_b = dt_op;
      end
      SP_P0X: begin
        mul_a = t_q;
        mul_b = dt_op;
      end
      SP_P11: begin
        mul_a = $signed({{(MA_W-CFG_W){1'b0}}, bpn_q});
        mul_b = dt_op;
      end
      SP_ANG: begin
        mul_a = MA_W'(k0_q);
        mul_b = MB_W'(y_q);
      end
      SP_BIAS: begin
        mul_a = MA_W'(k1_q);
        mul_b = MB_W'(y_q);
      end
      SP_U00: begin
        mul_a = MA_W'(k0_q);
        mul_b = MB_W'(pp00_q);
      end
      SP_U01: begin
        mul_a = MA_W'(k0_q);
        mul_b = MB_W'(pp01_q);
      end
      SP_U10: begin
        mul_a = MA_W'(k1_q);
        mul_b = MB_W'(pp00_q);
      end
      SP_U11: begin
        mul_a = MA_W'(k1_q);
        mul_b = MB_W'(pp01_q);
      end
      default: ;
    endcase
  end

  abkf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .rnd_o (m_rnd)
  );

  abkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_sum[DATA_W-1:0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Sequence: predict, divide twice unless the innovation variance is not positive, correct and update
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          state_d = ST_MUL;
          step_d  = SP_APRED;
        end
      end
      ST_MUL: state_d = ST_WB;
      ST_WB: begin
        if (step_q == SP_P11) begin
          state_d = ST_DIV0;
        end else if (step_q == SP_U11) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MUL;
          step_d  = step_q + 1'b1;
        end
      end
      ST_DIV0: begin
        if (s_pos) begin
          state_d = ST_DW0;
        end else begin
          state_d = ST_MUL;
          step_d  = SP_ANG;
        end
      end
      ST_DW0: begin
        if (div_done) begin
          state_d = ST_DIV1;
        end
      end
      ST_DIV1: state_d = ST_DW1;
      ST_DW1: begin
        if (div_done) begin
          state_d = ST_MUL;
          step_d  = SP_ANG;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= SP_APRED;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Filter state: estimates and covariance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ae_q   <= '0;
      bias_q <= '0;
      c00_q  <= '0;
      c01_q  <= '0;
      c10_q  <= '0;
      c11_q  <= '0;
    end else if (state_q == ST_WB) begin
      case (step_q)
        SP_ANG:  ae_q   <= sat32(acc_t'(apred_q) + acc_t'(m_rnd));
        SP_BIAS: bias_q <= sat32(acc_t'(bias_q) + acc_t'(m_rnd));
        SP_U00:  c00_q  <= sat32(acc_t'(pp00_q) - acc_t'(m_rnd));
        SP_U01:  c01_q  <= sat32(acc_t'(pp01_q) - acc_t'(m_rnd));
        SP_U10:  c10_q  <= sat32(acc_t'(pp10_q) - acc_t'(m_rnd));
        SP_U11:  c11_q  <= sat32(acc_t'(pp11_q) - acc_t'(m_rnd));
        default: ;
      endcase
    end
  end

  // Working values of one sample
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      meas_q <= s_axis_tdata[DATA_W-1:0];
      gyro_q <= s_axis_tdata[2*DATA_W-1:DATA_W];
    end
    if (state_q == ST_WB) begin
      case (step_q)
        SP_APRED: apred_q <= sat32(acc_t'(ae_q) + acc_t'(m_rnd));
        SP_D: begin
          d_q <= m_rnd[DATA_W:0];
          t_q <= MA_W'(m_rnd) - MA_W'(c01_q) - MA_W'(c10_q)
                 + $signed({{(MA_W-CFG_W){1'b0}}, apn_q});
          y_q <= sat32(acc_t'(meas_q) - acc_t'(apred_q));
        end
        SP_P0X: begin
          pp00_q <= sat32(acc_t'(c00_q) + acc_t'(m_rnd));
          pp01_q <= sat32(acc_t'(c01_q) - acc_t'(d_q));
          pp10_q <= sat32(acc_t'(c10_q) - acc_t'(d_q));
        end
        SP_P11: pp11_q <= sat32(acc_t'(c11_q) + acc_t'(m_rnd));
        default: ;
      endcase
    end
    // Zero gains when the innovation variance is not positive
    if (state_q == ST_DIV0 && !s_pos) begin
      k0_q <= '0;
      k1_q <= '0;
    end
    if (state_q == ST_DW0 && div_done) begin
      k0_q <= div_quo;
    end
    if (state_q == ST_DW1 && div_done) begin
      k1_q <= div_quo;
    end
  end

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ang_out_q  <= ae_q;
      bias_out_q <= bias_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {bias_out_q, ang_out_q};

endmodule

`default_nettype wire
